@@ rtl/core/button_click_hold_detector_assert.svh @@
// Assertion macros used by the checker file of the click/hold detector.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef BUTTON_CLICK_HOLD_DETECTOR_ASSERT_SVH
`define BUTTON_CLICK_HOLD_DETECTOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BCHD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BCHD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/bchd_pkg.sv @@
`default_nettype none

package bchd_pkg;

  // Button phase, one per button entry
  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_CLICK    = 2'd2,
    PH_HOLD     = 2'd3
  } phase_t;

  // Reported event
  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_CLICK = 2'd1,
    EV_HOLD  = 2'd2
  } event_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_CLICK    = 2'd1,
    REG_HOLD     = 2'd2
  } reg_idx_t;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned DELAY_W = 16;

  localparam logic [DELAY_W-1:0] DEBOUNCE_RESET = 16'd20;
  localparam logic [DELAY_W-1:0] CLICK_RESET    = 16'd180;
  localparam logic [DELAY_W-1:0] HOLD_RESET     = 16'd500;

  typedef struct packed {
    logic [DELAY_W-1:0] debounce_ms;
    logic [DELAY_W-1:0] click_window_ms;
    logic [DELAY_W-1:0] hold_delay_ms;
  } cfg_t;

  // One button's stored state
  typedef struct packed {
    phase_t            phase;
    logic [TIME_W-1:0] deadline;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{phase: PH_IDLE, deadline: '0};

  // Outcome of one check
  typedef struct packed {
    event_t ev;
    entry_t entry;
  } step_res_t;

endpackage

`default_nettype wire

@@ rtl/core/button_click_hold_detector.sv @@
`default_nettype none

// Click/hold detector for up to BUTTONS buttons (only indexes 0 to 3 can be
// addressed; a check of an index at or beyond BUTTONS changes nothing and
// reports no event in phase idle). One check is taken every clock while the
// input is not stalled: the transfer reads the button's phase and deadline
// from the state memory, and when the update stage goes on it updates the
// entry and loads the output register. A stalled result holds the update
// stage and then stalls the input. Back-to-back checks of the same button are
// served by forwarding the write-back into the memory read. The state is
// ready straight after reset, with no clearing pass. Configuration writes
// take effect on the next check.
module button_click_hold_detector #(
  parameter int BUTTONS = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // check channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_button_index,
  input  wire logic [bchd_pkg::TIME_W-1:0]   in_now_ms,
  input  wire logic                          in_pressed,
  input  wire logic                          in_interrupt_flag,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         out_event_code,
  output logic [1:0]                         out_phase_after,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [bchd_pkg::DELAY_W-1:0]  cfg_data
);
  import bchd_pkg::*;

  localparam int DEPTH = (BUTTONS < 4) ? BUTTONS : 4;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cfg_t              cfg;
  entry_t            rd_entry;
  step_res_t         res;

  logic              in_fire;
  logic              in_range;
  logic              s1_go;
  logic              s1_fire;
  logic              out_fire;
  logic              wr_en;

  logic              s1_valid_r;
  logic              s1_valid_nxt;
  logic [AW-1:0]     s1_addr_r;
  logic              s1_in_range_r;
  logic [TIME_W-1:0] s1_now_r;
  logic              s1_pressed_r;
  logic              s1_irq_r;

  logic              out_valid_r;
  logic              out_valid_nxt;
  event_t            out_ev_r;
  phase_t            out_phase_r;

  // Handshake
  assign in_range = 32'(in_button_index) < 32'(BUTTONS);
  assign s1_go    = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && s1_go;
  assign in_stall = s1_valid_r && !s1_go;
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid_r && !out_stall;
  assign wr_en    = s1_fire && s1_in_range_r;

  bchd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bchd_state_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_addr (in_button_index[AW-1:0]),
    .rd_data (rd_entry),
    .wr_en   (wr_en),
    .wr_addr (s1_addr_r),
    .wr_data (res.entry)
  );

  bchd_step u_step (
    .cur            (rd_entry),
    .cfg            (cfg),
    .now_ms         (s1_now_r),
    .pressed        (s1_pressed_r),
    .interrupt_flag (s1_irq_r),
    .res            (res)
  );

  // Advance the update stage
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Hold or refill the result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the check alongside the memory read
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_addr_r     <= in_button_index[AW-1:0];
      s1_in_range_r <= in_range;
      s1_now_r      <= in_now_ms;
      s1_pressed_r  <= in_pressed;
      s1_irq_r      <= in_interrupt_flag;
    end
  end

  // Load the result; an ignored check reports idle with no event
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      if (s1_in_range_r) begin
        out_ev_r    <= res.ev;
        out_phase_r <= res.entry.phase;
      end else begin
        out_ev_r    <= EV_NONE;
        out_phase_r <= PH_IDLE;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_event_code  = out_ev_r;
  assign out_phase_after = out_phase_r;

endmodule

`default_nettype wire

@@ rtl/core/bchd_cfg.sv @@
`default_nettype none

module bchd_cfg (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [bchd_pkg::DELAY_W-1:0] cfg_data,
  output bchd_pkg::cfg_t                 cfg
);
  import bchd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Select the register addressed by a write; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DEBOUNCE: cfg_nxt.debounce_ms     = cfg_data;
        REG_CLICK:    cfg_nxt.click_window_ms = cfg_data;
        REG_HOLD:     cfg_nxt.hold_delay_ms   = cfg_data;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms     <= DEBOUNCE_RESET;
      cfg_r.click_window_ms <= CLICK_RESET;
      cfg_r.hold_delay_ms   <= HOLD_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ rtl/core/bchd_state_mem.sv @@
`default_nettype none

module bchd_state_mem #(
  parameter int DEPTH = 4,
  parameter int AW    = 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_addr,
  output bchd_pkg::entry_t       rd_data,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire bchd_pkg::entry_t  wr_data
);
  import bchd_pkg::*;

  entry_t           mem_r [DEPTH];
  logic [DEPTH-1:0] valid_r;
  entry_t           rd_q_r;
  logic             rd_hit_r;
  logic             fwd;

  // A write to the entry being read in the same cycle wins over the array
  assign fwd = wr_en && (wr_addr == rd_addr);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      if (fwd) begin
        rd_q_r <= wr_data;
      end else begin
        rd_q_r <= mem_r[rd_addr];
      end
    end
  end

  // Track written entries; unwritten ones read as the reset entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_hit_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit_r <= fwd || valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_hit_r ? rd_q_r : ENTRY_RESET;

endmodule

`default_nettype wire

@@ rtl/core/bchd_step.sv @@
`default_nettype none

module bchd_step (
  input  wire bchd_pkg::entry_t            cur,
  input  wire bchd_pkg::cfg_t              cfg,
  input  wire logic [bchd_pkg::TIME_W-1:0] now_ms,
  input  wire logic                        pressed,
  input  wire logic                        interrupt_flag,
  output bchd_pkg::step_res_t              res
);
  import bchd_pkg::*;

  logic              expired;
  phase_t            phase_nxt;
  event_t            ev;
  logic [TIME_W-1:0] deadline_nxt;

  // Plain unsigned compare, no wrap handling
  assign expired = now_ms > cur.deadline;

  // Next phase
  always_comb begin
    phase_nxt = cur.phase;
    unique case (cur.phase)
      PH_IDLE: begin
        if (interrupt_flag && pressed) phase_nxt = PH_DEBOUNCE;
      end
      PH_DEBOUNCE: begin
        if (pressed && expired)         phase_nxt = PH_CLICK;
        else if (!pressed && !expired)  phase_nxt = PH_IDLE;
      end
      PH_CLICK: begin
        if (!pressed && !expired)       phase_nxt = PH_IDLE;
        else if (pressed && expired)    phase_nxt = PH_HOLD;
      end
      PH_HOLD: begin
        if (!pressed)                   phase_nxt = PH_IDLE;
      end
      default: phase_nxt = cur.phase;
    endcase
  end

  // Event and new deadline
  always_comb begin
    ev           = EV_NONE;
    deadline_nxt = cur.deadline;
    unique case (cur.phase)
      PH_IDLE: begin
        if (interrupt_flag && pressed) begin
          deadline_nxt = now_ms + TIME_W'(cfg.debounce_ms);
        end
      end
      PH_DEBOUNCE: begin
        if (pressed && expired) begin
          deadline_nxt = now_ms + TIME_W'(cfg.click_window_ms);
        end
      end
      PH_CLICK: begin
        if (!pressed && !expired) begin
          ev = EV_CLICK;
        end else if (pressed && expired) begin
          deadline_nxt = now_ms + TIME_W'(cfg.hold_delay_ms);
        end
      end
      PH_HOLD: begin
        if (pressed && expired) ev = EV_HOLD;
      end
      default: ev = EV_NONE;
    endcase
  end

  assign res.ev             = ev;
  assign res.entry.phase    = phase_nxt;
  assign res.entry.deadline = deadline_nxt;

endmodule

`default_nettype wire

@@ rtl/core/bchd_checker.sv @@
`default_nettype none

`include "button_click_hold_detector_assert.svh"

module bchd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] out_event_code,
  input wire logic [1:0] out_phase_after
);
  import bchd_pkg::*;

  // Only the three defined event codes may appear
  `BCHD_ASSERT_NOW(a_ev_code, out_valid, (out_event_code == EV_NONE) || (out_event_code == EV_CLICK) || (out_event_code == EV_HOLD), "undefined event code")

  // A click always returns the button to idle
  `BCHD_ASSERT_NOW(a_click_idle, out_valid && (out_event_code == EV_CLICK), out_phase_after == PH_IDLE, "click without return to idle")

  // A hold is only reported while the button stays in hold
  `BCHD_ASSERT_NOW(a_hold_phase, out_valid && (out_event_code == EV_HOLD), out_phase_after == PH_HOLD, "hold outside hold phase")

  // A stalled result stays put
  `BCHD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_event_code) && $stable(out_phase_after), "stalled result changed")

endmodule

bind button_click_hold_detector bchd_checker u_bchd_checker (.*);

`default_nettype wire
